// File: hdl/word_length_histogram_macros.svh
// Assertion macros used by the histogram back end
`ifndef WORD_LENGTH_HISTOGRAM_MACROS_SVH
`define WORD_LENGTH_HISTOGRAM_MACROS_SVH

// same-cycle implication, off while in reset
`define WLH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("word_length_histogram: check failed");

// next-cycle implication, off while in reset
`define WLH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("word_length_histogram: check failed");

`endif

// File: hdl/whl_pkg.sv
// Package: widths, character codes and the front-to-back command type
`timescale 1ns / 1ps
package whl_pkg;
	localparam int NUM_BINS_DEF = 64;
	localparam int CHAR_W       = 8;
	localparam int BIN_W        = 6;
	localparam int COUNT_W      = 16;
	localparam int LEN_W        = 7;
	localparam int QUEUE_DEPTH  = 4;

	localparam logic [LEN_W-1:0]   LEN_MAX   = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NL    = 8'h0a;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2c;
	localparam logic [CHAR_W-1:0] CH_COLON = 8'h3a;
	localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3b;

	typedef struct packed {
		logic             dump;
		logic             word_ok;
		logic [BIN_W-1:0] len;
	} cmd_t;

	function automatic logic is_delim(input logic [CHAR_W-1:0] ch);
		return (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_NL) ||
			(ch == CH_COMMA) || (ch == CH_SEMI) || (ch == CH_COLON);
	endfunction
endpackage

// File: hdl/whl_byte_if.sv
// Interface: text byte channel
`timescale 1ns / 1ps
interface whl_byte_if
	import whl_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              end_of_text;

	modport source(output valid, char_code, end_of_text, input ready);
	modport sink(input valid, char_code, end_of_text, output ready);
endinterface

// File: hdl/whl_bin_if.sv
// Interface: histogram bin result channel
`timescale 1ns / 1ps
interface whl_bin_if
	import whl_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [BIN_W-1:0]   bin_index;
	logic [COUNT_W-1:0] bin_count;
	logic [COUNT_W-1:0] tallest_count;
	logic [BIN_W-1:0]   widest_length;
	logic               last_bin;

	modport source(output valid, bin_index, bin_count, tallest_count, widest_length,
		last_bin, input ready);
	modport sink(input valid, bin_index, bin_count, tallest_count, widest_length,
		last_bin, output ready);
endinterface

// File: hdl/whl_fifo.sv
// Command queue between the byte front end and the bin back end
`timescale 1ns / 1ps
module whl_fifo
	import whl_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t pop_data,
	output logic empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

// File: hdl/whl_front.sv
// Front end: accept text bytes, track word length, queue bin commands
`timescale 1ns / 1ps
module whl_front
	import whl_pkg::*;
#(
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	whl_byte_if.sink text,
	output logic push,
	output cmd_t push_data,
	input  logic full
);
	logic [LEN_W-1:0] cur_len_q;
	logic             accept;
	logic             is_end;
	logic             is_sep;
	logic             len_ok;

	assign text.ready = !full;
	assign accept     = text.valid && text.ready;
	assign is_end     = text.end_of_text || (text.char_code == CH_NUL);
	assign is_sep     = is_delim(text.char_code);
	assign len_ok     = (cur_len_q != '0) && (cur_len_q < LEN_W'(NUM_BINS));

	assign push_data.dump    = is_end;
	assign push_data.word_ok = len_ok;
	assign push_data.len     = cur_len_q[BIN_W-1:0];
	assign push              = accept && (is_end || (is_sep && len_ok));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_len_q <= '0;
		end else if (accept) begin
			if (is_end || is_sep) begin
				cur_len_q <= '0;
			end else if (cur_len_q != LEN_MAX) begin
				cur_len_q <= cur_len_q + 1'b1;
			end
		end
	end
endmodule

// File: hdl/whl_back.sv
// Back end: bin memory update, histogram dump and clear
`timescale 1ns / 1ps
`include "word_length_histogram_macros.svh"
module whl_back
	import whl_pkg::*;
#(
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  logic cmd_avail,
	output logic cmd_pop,
	whl_bin_if.source hist
);
	localparam int AW = $clog2(NUM_BINS);

	typedef enum logic [1:0] {ST_IDLE, ST_INC, ST_DUMP_RD, ST_DUMP_OUT} state_t;

	state_t             state_q;
	logic [COUNT_W-1:0] mem [NUM_BINS];
	logic               vld_q [NUM_BINS];
	logic [COUNT_W-1:0] rd_data_q;
	logic               rd_vld_q;
	logic [BIN_W-1:0]   len_q;
	logic               dump_after_q;
	logic [BIN_W-1:0]   idx_q;
	logic [COUNT_W-1:0] tallest_q;
	logic [BIN_W-1:0]   widest_q;

	logic               out_valid_q;
	logic [BIN_W-1:0]   out_idx_q;
	logic [COUNT_W-1:0] out_count_q;
	logic [COUNT_W-1:0] out_tall_q;
	logic [BIN_W-1:0]   out_wide_q;
	logic               out_last_q;

	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic [COUNT_W-1:0] cur_count;
	logic [COUNT_W-1:0] new_count;
	logic               out_free;
	logic               out_load;
	logic               at_last;

	assign cur_count = rd_vld_q ? rd_data_q : '0;
	assign new_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
	assign out_free  = !out_valid_q || hist.ready;
	assign at_last   = (idx_q == BIN_W'(NUM_BINS - 1));
	assign out_load  = (state_q == ST_DUMP_OUT) && out_free;
	assign cmd_pop   = (state_q == ST_IDLE) && cmd_avail;
	assign wr_en     = (state_q == ST_INC);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				rd_en   = cmd_avail && cmd.word_ok;
				rd_addr = cmd.len[AW-1:0];
			end
			ST_DUMP_RD: begin
				rd_en = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[len_q[AW-1:0]] <= new_count;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rd_vld_q     <= 1'b0;
			len_q        <= '0;
			dump_after_q <= 1'b0;
			idx_q        <= '0;
			tallest_q    <= '0;
			widest_q     <= '0;
			out_valid_q  <= 1'b0;
			out_idx_q    <= '0;
			out_count_q  <= '0;
			out_tall_q   <= '0;
			out_wide_q   <= '0;
			out_last_q   <= 1'b0;
			for (int i = 0; i < NUM_BINS; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_idx_q   <= idx_q;
				out_count_q <= cur_count;
				out_tall_q  <= tallest_q;
				out_wide_q  <= widest_q;
				out_last_q  <= at_last;
			end else if (hist.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_avail) begin
						len_q        <= cmd.len;
						dump_after_q <= cmd.dump;
						idx_q        <= '0;
						if (cmd.word_ok) begin
							state_q <= ST_INC;
						end else if (cmd.dump) begin
							state_q <= ST_DUMP_RD;
						end
					end
				end
				ST_INC: begin
					vld_q[len_q[AW-1:0]] <= 1'b1;
					if (new_count > tallest_q) begin
						tallest_q <= new_count;
					end
					if (len_q > widest_q) begin
						widest_q <= len_q;
					end
					state_q <= dump_after_q ? ST_DUMP_RD : ST_IDLE;
				end
				ST_DUMP_RD: begin
					state_q <= ST_DUMP_OUT;
				end
				ST_DUMP_OUT: begin
					if (out_free) begin
						if (at_last) begin
							tallest_q <= '0;
							widest_q  <= '0;
							for (int i = 0; i < NUM_BINS; i++) begin
								vld_q[i] <= 1'b0;
							end
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_DUMP_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign hist.valid         = out_valid_q;
	assign hist.bin_index     = out_idx_q;
	assign hist.bin_count     = out_count_q;
	assign hist.tallest_count = out_tall_q;
	assign hist.widest_length = out_wide_q;
	assign hist.last_bin      = out_last_q;

	`WLH_ASSERT_IMP(a_last_is_top_bin, clk, arst_n, out_valid_q && out_last_q, out_idx_q == BIN_W'(NUM_BINS - 1))
	`WLH_ASSERT_IMP(a_count_within_tallest, clk, arst_n, out_valid_q, out_count_q <= out_tall_q)
	`WLH_ASSERT_IMP(a_filled_bin_within_widest, clk, arst_n, out_valid_q && (out_count_q != '0), out_idx_q <= out_wide_q)
	`WLH_ASSERT_IMP(a_inc_length_in_range, clk, arst_n, state_q == ST_INC, (len_q != '0) && ({1'b0, len_q} < LEN_W'(NUM_BINS)))
	`WLH_ASSERT_NXT(a_cleared_after_dump, clk, arst_n, out_load && at_last, (tallest_q == '0) && (widest_q == '0))
endmodule

// File: hdl/word_length_histogram.sv
// Top level: word length histogram over a text byte stream
//
//   channel | dir | beat contents
//   text    | in  | char_code[7:0], end_of_text
//   hist    | out | bin_index[5:0], bin_count[15:0], tallest_count[15:0],
//           |     | widest_length[5:0], last_bin
//
// Text bytes are taken one per cycle while the 4-entry command queue has room.
// Each closed word costs the bin memory a read, then a write back. End of text is popped
// (with a read and write back first if it closes a word), then dumps NUM_BINS beats
// (memory read, then output register); the last beat clears the valid flags.
// hist stalls hold the dump; a full command queue then stalls text.
`timescale 1ns / 1ps
module word_length_histogram
	import whl_pkg::*;
#(
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input logic clk,
	input logic arst_n,
	whl_byte_if.sink text,
	whl_bin_if.source hist
);
	logic push;
	cmd_t push_data;
	logic full;
	logic pop;
	cmd_t pop_data;
	logic empty;

	whl_front #(
		.NUM_BINS(NUM_BINS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	whl_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	whl_back #(
		.NUM_BINS(NUM_BINS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (pop_data),
		.cmd_avail (!empty),
		.cmd_pop   (pop),
		.hist      (hist)
	);
endmodule

// File: verif/word_length_histogram_checker.sv
// Checker: follows the text stream, predicts every histogram dump and compares it beat by beat
`timescale 1ns / 1ps
module word_length_histogram_checker
	import whl_pkg::*;
#(
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input logic clk,
	input logic arst_n,
	whl_byte_if text,
	whl_bin_if hist,
	output int unsigned fail_count,
	output int unsigned bins_pending
);
	typedef struct packed {
		logic [BIN_W-1:0]   bin_index;
		logic [COUNT_W-1:0] bin_count;
		logic [COUNT_W-1:0] tallest_count;
		logic [BIN_W-1:0]   widest_length;
		logic               last_bin;
	} bin_beat_t;

	localparam int REPORT_MAX = 40;

	logic [COUNT_W-1:0] tally [NUM_BINS];
	logic [LEN_W-1:0]   word_len;
	logic [COUNT_W-1:0] peak_count;
	logic [BIN_W-1:0]   widest_word;
	bin_beat_t          expected_bins [$];
	int unsigned        reports;

	function automatic logic is_separator(input logic [CHAR_W-1:0] ch);
		return ch inside {CH_SPACE, CH_TAB, CH_NL, CH_COMMA, CH_SEMI, CH_COLON};
	endfunction

	function automatic void clear_histogram();
		for (int i = 0; i < NUM_BINS; i++) begin
			tally[i] = '0;
		end
		word_len = '0;
		peak_count = '0;
		widest_word = '0;
	endfunction

	function automatic void close_word();
		if (word_len != 0 && word_len < NUM_BINS) begin
			if (tally[word_len[BIN_W-1:0]] != COUNT_MAX) begin
				tally[word_len[BIN_W-1:0]] = tally[word_len[BIN_W-1:0]] + 1'b1;
			end
			if (tally[word_len[BIN_W-1:0]] > peak_count) begin
				peak_count = tally[word_len[BIN_W-1:0]];
			end
			if (word_len > widest_word) begin
				widest_word = word_len[BIN_W-1:0];
			end
		end
		word_len = '0;
	endfunction

	function automatic void take_byte(input logic [CHAR_W-1:0] ch, input logic eot);
		bin_beat_t beat;
		if (!eot && ch != CH_NUL) begin
			if (is_separator(ch)) begin
				close_word();
			end else if (word_len != LEN_MAX) begin
				word_len = word_len + 1'b1;
			end
		end else begin
			close_word();
			for (int i = 0; i < NUM_BINS; i++) begin
				beat.bin_index = i[BIN_W-1:0];
				beat.bin_count = tally[i];
				beat.tallest_count = peak_count;
				beat.widest_length = widest_word;
				beat.last_bin = (i == NUM_BINS - 1);
				expected_bins.push_back(beat);
			end
			clear_histogram();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		bin_beat_t got;
		bin_beat_t want;
		if (!arst_n) begin
			clear_histogram();
			expected_bins.delete();
			reports = 0;
			fail_count <= 0;
			bins_pending <= 0;
		end else begin
			if (text.valid && text.ready) begin
				take_byte(text.char_code, text.end_of_text);
			end
			if (hist.valid && hist.ready) begin
				got.bin_index = hist.bin_index;
				got.bin_count = hist.bin_count;
				got.tallest_count = hist.tallest_count;
				got.widest_length = hist.widest_length;
				got.last_bin = hist.last_bin;
				if (expected_bins.size() == 0) begin
					fail_count <= fail_count + 1;
					if (reports < REPORT_MAX) begin
						$display("%0t: unexpected bin beat: expected none, got idx %0d count %0d",
							$time, got.bin_index, got.bin_count);
					end
					reports++;
				end else begin
					want = expected_bins.pop_front();
					if (got.bin_index !== want.bin_index || got.bin_count !== want.bin_count ||
						got.tallest_count !== want.tallest_count ||
						got.widest_length !== want.widest_length ||
						got.last_bin !== want.last_bin) begin
						fail_count <= fail_count + 1;
						if (reports < REPORT_MAX) begin
							$display({"%0t: bin beat mismatch: expected idx %0d count %0d ",
								"tallest %0d widest %0d last %0b, got idx %0d count %0d ",
								"tallest %0d widest %0d last %0b"}, $time,
								want.bin_index, want.bin_count, want.tallest_count,
								want.widest_length, want.last_bin,
								got.bin_index, got.bin_count, got.tallest_count,
								got.widest_length, got.last_bin);
						end
						reports++;
					end
				end
			end
			bins_pending <= expected_bins.size();
		end
	end
endmodule

// File: verif/word_length_histogram_tb.sv
// Testbench top: drives text streams into the histogram, stalls the bin channel, gives the verdict
`timescale 1ns / 1ps
module word_length_histogram_tb;
	import whl_pkg::*;

	localparam int ITEM_TARGET    = 420;
	localparam int CYCLE_LIMIT    = 2000000;
	localparam int DRAIN_CYCLES   = 300;
	localparam int LONG_LENGTHS [3] = '{63, 64, 130};

	typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} stall_mode_t;

	logic        clk;
	logic        arst_n;
	logic        gaps_on;
	int unsigned fail_count;
	int unsigned bins_pending;
	int unsigned cycle_count = 0;
	int unsigned burst_left;
	int unsigned items_sent;
	int unsigned stall_age = 0;
	stall_mode_t stall_mode = READY_ALWAYS;

	whl_byte_if text_ch();
	whl_bin_if  hist_ch();

	word_length_histogram dut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_ch),
		.hist(hist_ch)
	);

	word_length_histogram_checker hist_check (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_ch),
		.hist(hist_ch),
		.fail_count(fail_count),
		.bins_pending(bins_pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (stall_age == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_age <= $urandom_range(20, 150);
		end else begin
			stall_age <= stall_age - 1;
		end
		case (stall_mode)
			READY_ALWAYS: begin
				hist_ch.ready <= 1'b1;
			end
			READY_COIN: begin
				hist_ch.ready <= 1'($urandom_range(0, 1));
			end
			READY_SPARSE: begin
				hist_ch.ready <= ($urandom_range(0, 3) == 0);
			end
			default: begin
				hist_ch.ready <= (cycle_count % 5) != 0;
			end
		endcase
	end

	function automatic logic [CHAR_W-1:0] rand_letter();
		logic [CHAR_W-1:0] ch;
		do ch = 8'($urandom_range(1, 255)); while (is_delim(ch));
		return ch;
	endfunction

	function automatic logic [CHAR_W-1:0] rand_sep();
		case ($urandom_range(0, 5))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_NL;
			3: return CH_COMMA;
			4: return CH_SEMI;
			default: return CH_COLON;
		endcase
	endfunction

	task automatic put_byte(input logic [CHAR_W-1:0] ch, input logic eot);
		int unsigned gap;
		if (gaps_on && burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				text_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		text_ch.valid <= 1'b1;
		text_ch.char_code <= ch;
		text_ch.end_of_text <= eot;
		do @(posedge clk); while (!text_ch.ready);
		@(negedge clk);
		if (burst_left != 0) begin
			burst_left--;
		end
		items_sent++;
	endtask

	task automatic put_word(input int unsigned len);
		repeat (len) put_byte(rand_letter(), 1'b0);
	endtask

	task automatic put_string(input string s);
		for (int i = 0; i < s.len(); i++) begin
			put_byte(s[i], 1'b0);
		end
	endtask

	// hold the sender until the whole dump has drained
	task automatic hold_until_drained();
		text_ch.valid <= 1'b0;
		wait (bins_pending == 0);
		@(negedge clk);
	endtask

	task automatic put_random_text();
		int unsigned words;
		int unsigned pick;
		words = $urandom_range(0, 14);
		for (int w = 0; w < words; w++) begin
			if ($urandom_range(0, 32) == 0) begin
				put_byte(CH_NUL, 1'b0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				put_word($urandom_range(1, 10));
			end else if (pick < 90) begin
				put_word($urandom_range(11, 40));
			end else if (pick < 96) begin
				put_word($urandom_range(60, 68));
			end else begin
				put_word($urandom_range(120, 140));
			end
			if (w + 1 < words || $urandom_range(0, 1) == 0) begin
				repeat ($urandom_range(1, 3)) put_byte(rand_sep(), 1'b0);
			end
		end
		case ($urandom_range(0, 3))
			0: put_byte(CH_NUL, 1'b0);
			1: put_byte(rand_sep(), 1'b1);
			default: put_byte(8'($urandom_range(0, 255)), 1'b1);
		endcase
	endtask

	initial begin
		text_ch.valid = 1'b0;
		text_ch.char_code = '0;
		text_ch.end_of_text = 1'b0;
		arst_n = 1'b0;
		gaps_on = 1'b0;
		burst_left = 0;
		items_sent = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		put_byte(8'h41, 1'b1);
		put_string("ab c\td\ne,f;g:hh  ,;");
		put_byte(CH_NUL, 1'b0);
		put_byte(8'hff, 1'b0);
		put_byte(8'h80, 1'b0);
		put_byte(8'h7f, 1'b0);
		put_byte(CH_SPACE, 1'b1);
		hold_until_drained();

		gaps_on = 1'b1;
		foreach (LONG_LENGTHS[i]) begin
			put_word(LONG_LENGTHS[i]);
			put_byte(rand_sep(), 1'b0);
		end
		put_word(5);
		put_byte(rand_letter(), 1'b1);
		hold_until_drained();

		while (items_sent < ITEM_TARGET) begin
			put_random_text();
			if ($urandom_range(0, 9) == 0) begin
				hold_until_drained();
			end
		end

		text_ch.valid <= 1'b0;
		wait (bins_pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && bins_pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
